@@ sv/ftmr_pkg.sv @@
package ftmr_pkg;

	// Largest mesh coordinate on either axis
	localparam logic [1:0] MESH_MAX = 2'd2;

	localparam int COORD_W = 2;
	localparam int HOP_W   = 10;
	localparam int CFG_W   = 10;
	localparam int CFG_IDX_W = 3;

	localparam logic [HOP_W-1:0] HOP_LIMIT_RST = 10'd1000;

	// Faulty link codes; 4 and above mean no fault
	localparam logic [2:0] LINK_WEST  = 3'd0;
	localparam logic [2:0] LINK_SOUTH = 3'd1;
	localparam logic [2:0] LINK_EAST  = 3'd2;
	localparam logic [2:0] LINK_NORTH = 3'd3;
	localparam logic [2:0] LINK_NONE  = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT1_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT1_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT1_DIR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT2_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT2_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT2_DIR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HOP_LIMIT  = 3'd6;

	typedef enum logic [2:0] {
		H_NEW   = 3'd0,
		H_WEST  = 3'd1,
		H_SOUTH = 3'd2,
		H_EAST  = 3'd3,
		H_NORTH = 3'd4
	} heading_t;

	typedef enum logic [2:0] {
		DEC_DELIVER    = 3'd0,
		DEC_WEST       = 3'd1,
		DEC_SOUTH      = 3'd2,
		DEC_EAST       = 3'd3,
		DEC_NORTH      = 3'd4,
		DEC_UNROUTABLE = 3'd5
	} decision_t;

	typedef struct packed {
		logic               first_hop;
		logic [COORD_W-1:0] here_x;
		logic [COORD_W-1:0] here_y;
		logic [COORD_W-1:0] target_x;
		logic [COORD_W-1:0] target_y;
	} route_in_t;

	typedef struct packed {
		logic [2:0]         decision;
		logic [COORD_W-1:0] next_x;
		logic [COORD_W-1:0] next_y;
		logic               livelock;
	} route_out_t;

endpackage

@@ sv/fault_tolerant_mesh_route_step_top.sv @@
// Route step for a small 2D mesh with up to two faulty links.
//
// Channels: the item channel (item_valid / item_stall / item) carries one
// packet hop request: first_hop, current node and destination node. The
// result channel (result_valid / result_stall / result) returns one
// decision per item: deliver, a move west/south/east/north with the next
// coordinates, or unroutable, plus a livelock flag on a move once the hop
// count of the packet has reached hop_limit. A transfer happens on a rising
// edge with valid high and stall low.
// Configuration: cfg_we with cfg_index / cfg_data writes the fault links and
// hop_limit; write only while no item is in flight.
// Pipeline: an accepted item is held in the input register, the route
// decision is computed combinationally from it and the heading/hop-count
// state, and lands in the result register when the item advances, which
// needs the result register empty or being drained. One item per cycle is
// sustained while the receiver does not stall; a single priority chain of
// small compares lies between the two registers.
// Reset: both registers empty, heading new, hop count zero, no faulty links,
// hop_limit 1000. When the receiver stalls, the result register holds and
// the input register refills once, after which item_stall rises.
module fault_tolerant_mesh_route_step_top
	import ftmr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  route_in_t            item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output route_out_t           result
);

	// Configuration registers
	logic [COORD_W-1:0] fault1_x_q, fault1_y_q, fault2_x_q, fault2_y_q;
	logic [2:0]         fault1_dir_q, fault2_dir_q;
	logic [HOP_W-1:0]   hop_limit_q;

	// Per-packet routing state
	heading_t           heading_q;
	logic [HOP_W-1:0]   hop_count_q;

	// Input register stage
	logic               valid_s1;
	route_in_t          item_s1;

	// Result register
	logic               result_valid_q;
	route_out_t         result_q;

	logic               advance;
	logic               item_take;

	// Datapath of the decision
	heading_t           head_eff;
	logic [HOP_W-1:0]   hop_eff;
	logic [2:0]         cx, cy, dx, dy;
	logic               wok, sok, eok, nok, ws;
	decision_t          mv;
	logic               is_move;
	logic               at_limit;
	logic [COORD_W-1:0] nx, ny;
	heading_t           head_next;
	logic [HOP_W-1:0]   hop_next;

	// Move s1 forward when the result register is empty or being drained
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign item_take  = item_valid && !item_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault1_x_q   <= '0;
			fault1_y_q   <= '0;
			fault1_dir_q <= LINK_NONE;
			fault2_x_q   <= '0;
			fault2_y_q   <= '0;
			fault2_dir_q <= LINK_NONE;
			hop_limit_q  <= HOP_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FAULT1_X:   fault1_x_q   <= cfg_data[COORD_W-1:0];
				CFG_FAULT1_Y:   fault1_y_q   <= cfg_data[COORD_W-1:0];
				CFG_FAULT1_DIR: fault1_dir_q <= cfg_data[2:0];
				CFG_FAULT2_X:   fault2_x_q   <= cfg_data[COORD_W-1:0];
				CFG_FAULT2_Y:   fault2_y_q   <= cfg_data[COORD_W-1:0];
				CFG_FAULT2_DIR: fault2_dir_q <= cfg_data[2:0];
				CFG_HOP_LIMIT:  hop_limit_q  <= cfg_data[HOP_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1 <= item;
		end
	end

	// A first hop starts from a fresh heading and a cleared count
	assign head_eff = item_s1.first_hop ? H_NEW : heading_q;
	assign hop_eff  = item_s1.first_hop ? '0 : hop_count_q;

	// Widen coordinates so that +1 cannot wrap
	assign cx = {1'b0, item_s1.here_x};
	assign cy = {1'b0, item_s1.here_y};
	assign dx = {1'b0, item_s1.target_x};
	assign dy = {1'b0, item_s1.target_y};

	// A link is usable unless one of the fault registers names it
	always_comb begin
		logic here1, here2;
		here1 = (item_s1.here_x == fault1_x_q) && (item_s1.here_y == fault1_y_q);
		here2 = (item_s1.here_x == fault2_x_q) && (item_s1.here_y == fault2_y_q);
		wok = !((here1 && fault1_dir_q == LINK_WEST)  || (here2 && fault2_dir_q == LINK_WEST));
		sok = !((here1 && fault1_dir_q == LINK_SOUTH) || (here2 && fault2_dir_q == LINK_SOUTH));
		eok = !((here1 && fault1_dir_q == LINK_EAST)  || (here2 && fault2_dir_q == LINK_EAST));
		nok = !((here1 && fault1_dir_q == LINK_NORTH) || (here2 && fault2_dir_q == LINK_NORTH));
	end

	assign ws = (head_eff == H_WEST) || (head_eff == H_SOUTH) || (head_eff == H_NEW);

	// Priority chain: deliver, direct hops, west/south, east/north, then fallbacks
	always_comb begin
		logic x_lo, y_lo;
		x_lo = (item_s1.here_x < MESH_MAX);
		y_lo = (item_s1.here_y < MESH_MAX);
		priority if (cx == dx && cy == dy) begin
			mv = DEC_DELIVER;
		end else if (cx == dx + 3'd1 && cy == dy && wok) begin
			mv = DEC_WEST;
		end else if (cy == dy + 3'd1 && cx == dx && sok) begin
			mv = DEC_SOUTH;
		end else if (cx + 3'd1 == dx && cy == dy && eok && x_lo) begin
			mv = DEC_EAST;
		end else if (cy + 3'd1 == dy && cx == dx && nok && y_lo) begin
			mv = DEC_NORTH;
		end else if (cx != 3'd0 && ws && wok && (cx >= dx || (cy <= dy && !sok))) begin
			mv = DEC_WEST;
		end else if (cy != 3'd0 && ws && sok && (cy >= dy || (cx <= dx && !wok))) begin
			mv = DEC_SOUTH;
		end else if (x_lo && head_eff != H_WEST && eok &&
				(dx > cx + 3'd1 || (dx == cx + 3'd1 && dy == cy + 3'd1))) begin
			mv = DEC_EAST;
		end else if (y_lo && head_eff != H_SOUTH && nok && dy > cy) begin
			mv = DEC_NORTH;
		end else if (cx != 3'd0 && cx >= dx && head_eff != H_EAST && wok) begin
			mv = DEC_WEST;
		end else if (cy != 3'd0 && cy >= dx && head_eff != H_NORTH && sok) begin
			mv = DEC_SOUTH;
		end else if (x_lo && cx <= dx && (head_eff != H_WEST || cx == dx ||
				(cx + 3'd1 == dx && cy + 3'd1 != dx)) && eok) begin
			mv = DEC_EAST;
		end else if (y_lo && cy <= dy && (head_eff != H_SOUTH || cx <= dx) && nok) begin
			mv = DEC_NORTH;
		end else begin
			mv = DEC_UNROUTABLE;
		end
	end

	// Next coordinates; deliver and unroutable repeat the current node
	always_comb begin
		nx = item_s1.here_x;
		ny = item_s1.here_y;
		is_move = 1'b1;
		unique case (mv)
			DEC_WEST:  nx = item_s1.here_x - 2'd1;
			DEC_SOUTH: ny = item_s1.here_y - 2'd1;
			DEC_EAST:  nx = item_s1.here_x + 2'd1;
			DEC_NORTH: ny = item_s1.here_y + 2'd1;
			default:   is_move = 1'b0;
		endcase
	end

	// Saturate the hop count at the limit and flag livelock there
	assign at_limit  = (hop_eff >= hop_limit_q);
	assign head_next = is_move ? heading_t'(mv) : head_eff;
	assign hop_next  = (is_move && !at_limit) ? hop_eff + 10'd1 : hop_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q   <= H_NEW;
			hop_count_q <= '0;
		end else if (advance) begin
			heading_q   <= head_next;
			hop_count_q <= hop_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.decision <= mv;
			result_q.next_x   <= nx;
			result_q.next_y   <= ny;
			result_q.livelock <= is_move && at_limit;
		end
	end

	// The input side stalls only with an item parked in the input register
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("item_stall raised with empty input register");

	// Livelock comes only with a move
	a_livelock_move: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.livelock) |->
		(result.decision == DEC_WEST || result.decision == DEC_SOUTH ||
		 result.decision == DEC_EAST || result.decision == DEC_NORTH))
		else $error("livelock flagged without a move");

	// Routing state holds while no item advances
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(heading_q) && $stable(hop_count_q)))
		else $error("routing state changed without an advancing item");

	// A first hop that does not move leaves the count cleared
	a_first_hop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.first_hop && !is_move) |=>
		(hop_count_q == '0 && heading_q == H_NEW))
		else $error("first hop did not clear routing state");

	// An item advancing makes a result available next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("advanced item produced no result");

endmodule
